// ===== src/can_chunked_payload_responder_core_assert.svh =====
// Assertion macros shared by the responder modules.
`ifndef CAN_CHUNKED_PAYLOAD_RESPONDER_CORE_ASSERT_SVH
`define CAN_CHUNKED_PAYLOAD_RESPONDER_CORE_ASSERT_SVH
`ifndef SYNTHESIS
// Check a property on every rising edge outside reset.
`define CPR_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("responder assertion failed");
// Check that a condition never holds outside reset.
`define CPR_ASSERT_NEVER(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("responder condition must never hold");
`else
`define CPR_ASSERT(label, clk, rst, prop)
`define CPR_ASSERT_NEVER(label, clk, rst, expr)
`endif
`endif

// ===== src/cpr_pkg.sv =====
// Types, frame identifiers and fixed frame contents of the chunked payload responder.
package cpr_pkg;

   localparam int unsigned PAYLOAD_DEPTH_DEFAULT = 1024;
   localparam int unsigned QUEUE_DEPTH           = 4;
   localparam int unsigned QUEUE_PTR_W           = $clog2(QUEUE_DEPTH);

   // Frame identifiers
   localparam logic [28:0] ID_POLL       = 29'h0001_0000;
   localparam logic [28:0] ID_POLL_REPLY = 29'h0002_ABCD;
   localparam logic [28:0] ID_DATA_REQ   = 29'h0014_ABCD;
   localparam logic [28:0] ID_DEVICE     = 29'h001D_ABCD;
   localparam logic [28:0] ID_WRAPPER    = 29'h0025_ABCD;
   localparam logic [28:0] ID_CHUNK      = 29'h000C_ABCD;
   localparam logic [28:0] ID_MODEM      = 29'h001C_ABCD;
   localparam logic [28:0] ID_ACK        = 29'h000B_ABCD;

   localparam logic MODE_LOAD = 1'b1;

   // Counter limits and trigger values
   localparam logic [2:0] EXCHANGE_MAX    = 3'd4;
   localparam logic [2:0] EXCHANGE_DEVICE = 3'd3;
   localparam logic [1:0] ACK_MAX         = 2'd3;
   localparam logic [1:0] ACK_CONFIRM     = 2'd2;
   localparam logic [7:0] CHUNK_COUNT_MAX = 8'hFF;

   // Frame lengths
   localparam logic [3:0] CHUNK_BYTES   = 4'd8;
   localparam logic [3:0] HANDSHAKE_LEN = 4'd8;
   localparam logic [3:0] POLL_LEN      = 4'd1;
   localparam logic [3:0] DEVICE_LEN    = 4'd6;
   localparam logic [3:0] WRAPPER_LEN   = 4'd3;

   // Eight data bytes, element 0 is byte 0
   typedef logic [7:0][7:0] frame_data_type;

   localparam frame_data_type HANDSHAKE_BYTES =
      {8'h9A, 8'h00, 8'h00, 8'h16, 8'h12, 8'h00, 8'h01, 8'h01};
   localparam frame_data_type DEVICE_BYTES =
      {8'h00, 8'h00, 8'h00, 8'h01, 8'h10, 8'h70, 8'h01, 8'h01};
   localparam frame_data_type BEGIN_BYTES =
      {8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h01};
   localparam frame_data_type END_BYTES =
      {8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h01, 8'h00, 8'h01};

   typedef enum logic [1:0] {
      KIND_FRAME   = 2'd0,
      KIND_MODEM   = 2'd1,
      KIND_CONFIRM = 2'd2
   } result_kind_type;

   // Work handed from the classifier to the executing side
   typedef enum logic [3:0] {
      CMD_LOAD,
      CMD_HANDSHAKE,
      CMD_POLL_REPLY,
      CMD_DEVICE,
      CMD_BEGIN,
      CMD_CHUNK,
      CMD_END,
      CMD_MODEM,
      CMD_CONFIRM
   } cmd_code_type;

   typedef struct packed {
      cmd_code_type code;
      logic [10:0]  start;
      logic [3:0]   length;
      logic [9:0]   load_address;
      logic [7:0]   load_byte;
   } cmd_type;

   typedef struct packed {
      result_kind_type kind;
      logic [28:0]     tx_id;
      logic [3:0]      tx_length;
      frame_data_type  tx_data;
   } result_type;

endpackage

// ===== src/cpr_front.sv =====
// Front end: configuration register, frame classification and exchange counters.
`include "can_chunked_payload_responder_core_assert.svh"

module cpr_front #(
   parameter int unsigned PAYLOAD_DEPTH = cpr_pkg::PAYLOAD_DEPTH_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [10:0]      csr_payload_length,
   input  logic             req_valid,
   output logic             req_ready,
   input  logic             req_mode,
   input  logic [28:0]      req_frame_id,
   input  logic [7:0]       req_first_data_byte,
   input  logic [7:0]       req_second_data_byte,
   input  logic [9:0]       req_load_address,
   input  logic [7:0]       req_load_byte,
   output logic             push_valid,
   input  logic             push_ready,
   output cpr_pkg::cmd_type push_cmd
);

   logic [10:0] payload_length_ff;
   logic [2:0]  exchange_count_ff, exchange_count_in;
   logic [7:0]  chunk_count_ff, chunk_count_in;
   logic [10:0] bytes_sent_ff, bytes_sent_in;
   logic [1:0]  ack_count_ff, ack_count_in;

   logic        accept;
   logic [10:0] length_cap;
   logic [8:0]  last_chunk;
   logic [8:0]  end_chunk;
   logic [8:0]  chunk_wide;
   logic [10:0] remain;
   logic [3:0]  chunk_len;
   logic [2:0]  exchange_next;
   logic [7:0]  chunk_next;
   logic [1:0]  ack_next;

   assign csr_ready = 1'b1;
   assign req_ready = push_ready;
   assign accept    = req_valid && push_ready;

   // Hold the payload length register
   always_ff @(posedge clock) begin
      if (reset) begin
         payload_length_ff <= '0;
      end else if (csr_valid) begin
         payload_length_ff <= csr_payload_length;
      end
   end

   // Chunk sizing from the capped length
   always_comb begin
      length_cap = (32'(payload_length_ff) > PAYLOAD_DEPTH) ? 11'(PAYLOAD_DEPTH)
                                                            : payload_length_ff;
      last_chunk = {1'b0, length_cap[10:3]} + 9'd1;
      end_chunk  = last_chunk + 9'd1;
      chunk_wide = {1'b0, chunk_count_ff};
      remain     = length_cap - bytes_sent_ff;
      if (bytes_sent_ff >= length_cap) begin
         chunk_len = '0;
      end else if (remain > 11'(cpr_pkg::CHUNK_BYTES)) begin
         chunk_len = cpr_pkg::CHUNK_BYTES;
      end else begin
         chunk_len = remain[3:0];
      end
      exchange_next = (exchange_count_ff == cpr_pkg::EXCHANGE_MAX) ? exchange_count_ff
                                                                   : exchange_count_ff + 3'd1;
      chunk_next    = (chunk_count_ff == cpr_pkg::CHUNK_COUNT_MAX) ? chunk_count_ff
                                                                   : chunk_count_ff + 8'd1;
      ack_next      = (ack_count_ff == cpr_pkg::ACK_MAX) ? ack_count_ff : ack_count_ff + 2'd1;
   end

   // Classify the beat and advance the counters
   always_comb begin
      exchange_count_in     = exchange_count_ff;
      chunk_count_in        = chunk_count_ff;
      bytes_sent_in         = bytes_sent_ff;
      ack_count_in          = ack_count_ff;
      push_valid            = 1'b0;
      push_cmd.code         = cpr_pkg::CMD_LOAD;
      push_cmd.start        = bytes_sent_ff;
      push_cmd.length       = chunk_len;
      push_cmd.load_address = req_load_address;
      push_cmd.load_byte    = req_load_byte;
      if (accept) begin
         if (req_mode == cpr_pkg::MODE_LOAD) begin
            push_valid = (32'(req_load_address) < PAYLOAD_DEPTH);
         end else if (req_frame_id == cpr_pkg::ID_POLL) begin
            push_valid        = 1'b1;
            push_cmd.code     = (exchange_count_ff == '0) ? cpr_pkg::CMD_HANDSHAKE
                                                          : cpr_pkg::CMD_POLL_REPLY;
            exchange_count_in = exchange_next;
         end else if (req_frame_id == cpr_pkg::ID_DATA_REQ) begin
            if (exchange_count_ff == cpr_pkg::EXCHANGE_DEVICE) begin
               push_valid    = 1'b1;
               push_cmd.code = cpr_pkg::CMD_DEVICE;
            end else if (exchange_count_ff == cpr_pkg::EXCHANGE_MAX
                         && chunk_count_ff == '0) begin
               push_valid     = 1'b1;
               push_cmd.code  = cpr_pkg::CMD_BEGIN;
               chunk_count_in = chunk_next;
            end else if (exchange_count_ff == cpr_pkg::EXCHANGE_MAX
                         && chunk_wide <= last_chunk) begin
               push_valid     = 1'b1;
               push_cmd.code  = cpr_pkg::CMD_CHUNK;
               bytes_sent_in  = bytes_sent_ff + 11'(chunk_len);
               chunk_count_in = chunk_next;
            end else if (chunk_wide == end_chunk) begin
               push_valid     = 1'b1;
               push_cmd.code  = cpr_pkg::CMD_END;
               chunk_count_in = chunk_next;
            end
            exchange_count_in = exchange_next;
         end else if (req_frame_id == cpr_pkg::ID_MODEM && req_first_data_byte == 8'd0
                      && req_second_data_byte == 8'd0) begin
            push_valid    = 1'b1;
            push_cmd.code = cpr_pkg::CMD_MODEM;
         end else if (req_frame_id == cpr_pkg::ID_ACK) begin
            ack_count_in = ack_next;
            if (ack_next == cpr_pkg::ACK_CONFIRM) begin
               push_valid    = 1'b1;
               push_cmd.code = cpr_pkg::CMD_CONFIRM;
            end
         end
      end
   end

   // Hold the exchange counters
   always_ff @(posedge clock) begin
      if (reset) begin
         exchange_count_ff <= '0;
         chunk_count_ff    <= '0;
         bytes_sent_ff     <= '0;
         ack_count_ff      <= '0;
      end else begin
         exchange_count_ff <= exchange_count_in;
         chunk_count_ff    <= chunk_count_in;
         bytes_sent_ff     <= bytes_sent_in;
         ack_count_ff      <= ack_count_in;
      end
   end

   `CPR_ASSERT(a_chunks_follow_device_id, clock, reset, chunk_count_ff != 8'd0 |-> exchange_count_ff == cpr_pkg::EXCHANGE_MAX)

endmodule

// ===== src/cpr_queue.sv =====
// Short command queue between the classifier and the executing side.
`include "can_chunked_payload_responder_core_assert.svh"

module cpr_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  cpr_pkg::cmd_type push_cmd,
   output logic             pop_valid,
   input  logic             pop_ready,
   output cpr_pkg::cmd_type pop_cmd
);

   localparam int unsigned COUNT_W = $clog2(cpr_pkg::QUEUE_DEPTH + 1);

   cpr_pkg::cmd_type                entry_ff [cpr_pkg::QUEUE_DEPTH];
   logic [cpr_pkg::QUEUE_PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [COUNT_W-1:0]              count_ff, count_in;
   logic                            push, pop;

   assign push_ready = (count_ff != COUNT_W'(cpr_pkg::QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;
   assign pop_cmd    = entry_ff[rd_ptr_ff];

   // Track the fill level
   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + COUNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - COUNT_W'(1);
      end
   end

   // Advance the pointers
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + cpr_pkg::QUEUE_PTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + cpr_pkg::QUEUE_PTR_W'(1);
         end
      end
   end

   // Store the entries
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   `CPR_ASSERT(a_empty_pointers_meet, clock, reset, count_ff == '0 |-> wr_ptr_ff == rd_ptr_ff)

endmodule

// ===== src/cpr_back.sv =====
// Back end: banked payload store, chunk assembly and the result register.
`include "can_chunked_payload_responder_core_assert.svh"

module cpr_back #(
   parameter int unsigned PAYLOAD_DEPTH = cpr_pkg::PAYLOAD_DEPTH_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                pop_valid,
   output logic                pop_ready,
   input  cpr_pkg::cmd_type    pop_cmd,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output cpr_pkg::result_type rsp_result
);

   localparam int unsigned ROWS  = (PAYLOAD_DEPTH + 7) / 8;
   localparam int unsigned ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam int unsigned SUM_W = (ROW_W > 9) ? ROW_W : 9;

   logic [7:0]          mem [8][ROWS];
   logic [7:0]          bank_data_ff [8];
   logic                s1_valid_ff;
   cpr_pkg::cmd_type    s1_cmd_ff;
   logic                out_valid_ff;
   cpr_pkg::result_type out_result_ff, result_in;

   logic                pop, s1_advance, load_en, read_en;
   logic [SUM_W-1:0]    base_row;
   logic [SUM_W-1:0]    rd_sum [8];
   logic [ROW_W-1:0]    rd_row [8];
   logic [ROW_W-1:0]    load_row;

   assign s1_advance = !out_valid_ff || rsp_ready;
   assign pop_ready  = !s1_valid_ff || s1_advance;
   assign pop        = pop_valid && pop_ready;
   assign load_en    = pop && pop_cmd.code == cpr_pkg::CMD_LOAD;
   assign read_en    = pop && pop_cmd.code == cpr_pkg::CMD_CHUNK;
   assign base_row   = SUM_W'(pop_cmd.start[10:3]);
   assign load_row   = ROW_W'(pop_cmd.load_address[9:3]);

   // Banks below the start offset read from the next row
   always_comb begin
      for (int b = 0; b < 8; b++) begin
         rd_sum[b] = base_row + ((3'(b) < pop_cmd.start[2:0]) ? SUM_W'(1) : SUM_W'(0));
         rd_row[b] = rd_sum[b][ROW_W-1:0];
      end
   end

   // Write load bytes and read one row slice per bank
   always_ff @(posedge clock) begin
      for (int b = 0; b < 8; b++) begin
         if (load_en && pop_cmd.load_address[2:0] == 3'(b)) begin
            mem[b][load_row] <= pop_cmd.load_byte;
         end
         if (read_en) begin
            bank_data_ff[b] <= mem[b][rd_row[b]];
         end
      end
   end

   // Assemble the result
   always_comb begin
      result_in      = '0;
      result_in.kind = cpr_pkg::KIND_FRAME;
      unique case (s1_cmd_ff.code)
         cpr_pkg::CMD_HANDSHAKE: begin
            result_in.tx_id     = cpr_pkg::ID_POLL_REPLY;
            result_in.tx_length = cpr_pkg::HANDSHAKE_LEN;
            result_in.tx_data   = cpr_pkg::HANDSHAKE_BYTES;
         end
         cpr_pkg::CMD_POLL_REPLY: begin
            result_in.tx_id     = cpr_pkg::ID_POLL_REPLY;
            result_in.tx_length = cpr_pkg::POLL_LEN;
         end
         cpr_pkg::CMD_DEVICE: begin
            result_in.tx_id     = cpr_pkg::ID_DEVICE;
            result_in.tx_length = cpr_pkg::DEVICE_LEN;
            result_in.tx_data   = cpr_pkg::DEVICE_BYTES;
         end
         cpr_pkg::CMD_BEGIN: begin
            result_in.tx_id     = cpr_pkg::ID_WRAPPER;
            result_in.tx_length = cpr_pkg::WRAPPER_LEN;
            result_in.tx_data   = cpr_pkg::BEGIN_BYTES;
         end
         cpr_pkg::CMD_CHUNK: begin
            result_in.tx_id     = cpr_pkg::ID_CHUNK;
            result_in.tx_length = s1_cmd_ff.length;
            // rotate bank order to byte order, drop bytes past the chunk length
            for (int i = 0; i < 8; i++) begin
               if (4'(i) < s1_cmd_ff.length) begin
                  result_in.tx_data[i] = bank_data_ff[3'(s1_cmd_ff.start[2:0] + 3'(i))];
               end
            end
         end
         cpr_pkg::CMD_END: begin
            result_in.tx_id     = cpr_pkg::ID_WRAPPER;
            result_in.tx_length = cpr_pkg::WRAPPER_LEN;
            result_in.tx_data   = cpr_pkg::END_BYTES;
         end
         cpr_pkg::CMD_MODEM: begin
            result_in.kind = cpr_pkg::KIND_MODEM;
         end
         cpr_pkg::CMD_CONFIRM: begin
            result_in.kind = cpr_pkg::KIND_CONFIRM;
         end
         default: begin
         end
      endcase
   end

   // Advance the pipeline valids
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (pop_ready) begin
            s1_valid_ff <= pop && pop_cmd.code != cpr_pkg::CMD_LOAD;
         end
         if (s1_advance) begin
            out_valid_ff <= s1_valid_ff;
         end
      end
   end

   // Capture command and result payloads
   always_ff @(posedge clock) begin
      if (pop) begin
         s1_cmd_ff <= pop_cmd;
      end
      if (s1_valid_ff && s1_advance) begin
         out_result_ff <= result_in;
      end
   end

   assign rsp_valid  = out_valid_ff;
   assign rsp_result = out_result_ff;

   `CPR_ASSERT(a_status_has_no_data, clock, reset, out_valid_ff && out_result_ff.kind != cpr_pkg::KIND_FRAME |-> out_result_ff.tx_length == 4'd0)
   `CPR_ASSERT_NEVER(a_chunk_fits_frame, clock, reset, s1_valid_ff && s1_cmd_ff.length > cpr_pkg::CHUNK_BYTES)
   `CPR_ASSERT_NEVER(a_no_load_in_stage, clock, reset, s1_valid_ff && s1_cmd_ff.code == cpr_pkg::CMD_LOAD)

endmodule

// ===== src/can_chunked_payload_responder_core.sv =====
// A frame beat passes through the command queue, the s1 stage and the result register.
// One beat per cycle while the command queue has room; the banked payload store reads one
// eight-byte row slice per cycle and takes one load byte per cycle into one of its banks.
// Reset clears the counters, the payload length, the queue and the pipeline valids;
// the payload store is not cleared and holds whatever was loaded. csr_ready is always high.
module can_chunked_payload_responder_core #(
   parameter int unsigned PAYLOAD_DEPTH = cpr_pkg::PAYLOAD_DEPTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [10:0] csr_payload_length,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_mode,
   input  logic [28:0] req_frame_id,
   input  logic [7:0]  req_first_data_byte,
   input  logic [7:0]  req_second_data_byte,
   input  logic [9:0]  req_load_address,
   input  logic [7:0]  req_load_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_result_kind,
   output logic [28:0] rsp_tx_id,
   output logic [3:0]  rsp_tx_length,
   output logic [7:0]  rsp_tx_byte0,
   output logic [7:0]  rsp_tx_byte1,
   output logic [7:0]  rsp_tx_byte2,
   output logic [7:0]  rsp_tx_byte3,
   output logic [7:0]  rsp_tx_byte4,
   output logic [7:0]  rsp_tx_byte5,
   output logic [7:0]  rsp_tx_byte6,
   output logic [7:0]  rsp_tx_byte7
);

   logic                push_valid, push_ready;
   cpr_pkg::cmd_type    push_cmd;
   logic                pop_valid, pop_ready;
   cpr_pkg::cmd_type    pop_cmd;
   cpr_pkg::result_type rsp_result;

   // Classify beats and keep the exchange state
   cpr_front #(
      .PAYLOAD_DEPTH(PAYLOAD_DEPTH)
   ) u_front (
      .clock               (clock),
      .reset               (reset),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_payload_length  (csr_payload_length),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_mode            (req_mode),
      .req_frame_id        (req_frame_id),
      .req_first_data_byte (req_first_data_byte),
      .req_second_data_byte(req_second_data_byte),
      .req_load_address    (req_load_address),
      .req_load_byte       (req_load_byte),
      .push_valid          (push_valid),
      .push_ready          (push_ready),
      .push_cmd            (push_cmd)
   );

   // Decouple the two sides
   cpr_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push_valid(push_valid),
      .push_ready(push_ready),
      .push_cmd  (push_cmd),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_cmd   (pop_cmd)
   );

   // Carry out loads and build results
   cpr_back #(
      .PAYLOAD_DEPTH(PAYLOAD_DEPTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_cmd   (pop_cmd),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_result(rsp_result)
   );

   // Split the result onto its ports
   assign rsp_result_kind = rsp_result.kind;
   assign rsp_tx_id       = rsp_result.tx_id;
   assign rsp_tx_length   = rsp_result.tx_length;
   assign rsp_tx_byte0    = rsp_result.tx_data[0];
   assign rsp_tx_byte1    = rsp_result.tx_data[1];
   assign rsp_tx_byte2    = rsp_result.tx_data[2];
   assign rsp_tx_byte3    = rsp_result.tx_data[3];
   assign rsp_tx_byte4    = rsp_result.tx_data[4];
   assign rsp_tx_byte5    = rsp_result.tx_data[5];
   assign rsp_tx_byte6    = rsp_result.tx_data[6];
   assign rsp_tx_byte7    = rsp_result.tx_data[7];

endmodule

// ===== bench/can_chunked_payload_responder_core_test.sv =====
`timescale 1ns / 100ps
// Self-checking bench for the chunked payload responder: a directed table, then random beats.
module can_chunked_payload_responder_core_test;

   typedef cpr_pkg::result_type frame_rsp_type;

   localparam int unsigned STORE_DEPTH   = 1024;
   localparam int          DRAIN_LIMIT   = 20000;
   localparam int          SETTLE_CYCLES = 8;

   // Identifiers of received and transmitted frames
   localparam logic [28:0] RX_POLL       = 29'h0001_0000;
   localparam logic [28:0] RX_DATA_REQ   = 29'h0014_ABCD;
   localparam logic [28:0] RX_MODEM      = 29'h001C_ABCD;
   localparam logic [28:0] RX_ACK        = 29'h000B_ABCD;
   localparam logic [28:0] TX_POLL_REPLY = 29'h0002_ABCD;
   localparam logic [28:0] TX_DEVICE     = 29'h001D_ABCD;
   localparam logic [28:0] TX_WRAPPER    = 29'h0025_ABCD;
   localparam logic [28:0] TX_CHUNK      = 29'h000C_ABCD;

   localparam logic BEAT_FRAME = 1'b0;
   localparam logic BEAT_LOAD  = 1'b1;
   localparam logic TYPED      = 1'b1;
   localparam logic PREDICTED  = 1'b0;

   localparam logic [2:0] EXCH_DEVICE = 3'd3;
   localparam logic [2:0] EXCH_MAX    = 3'd4;
   localparam logic [1:0] ACK_CONFIRM = 2'd2;
   localparam logic [1:0] ACK_MAX     = 2'd3;
   localparam logic [7:0] CHUNK_MAX   = 8'hFF;

   // Fixed result frames; data byte 0 sits in the low byte
   localparam frame_rsp_type NO_RSP        = '0;
   localparam frame_rsp_type HANDSHAKE_RSP =
      {cpr_pkg::KIND_FRAME, TX_POLL_REPLY, 4'd8, 64'h9A00_0016_1200_0101};
   localparam frame_rsp_type POLL_ZERO_RSP = {cpr_pkg::KIND_FRAME, TX_POLL_REPLY, 4'd1, 64'd0};
   localparam frame_rsp_type DEVICE_RSP    =
      {cpr_pkg::KIND_FRAME, TX_DEVICE, 4'd6, 64'h0000_0001_1070_0101};
   localparam frame_rsp_type BEGIN_RSP     =
      {cpr_pkg::KIND_FRAME, TX_WRAPPER, 4'd3, 64'h0000_0000_0000_0001};
   localparam frame_rsp_type END_RSP       =
      {cpr_pkg::KIND_FRAME, TX_WRAPPER, 4'd3, 64'h0000_0000_0001_0001};
   localparam frame_rsp_type EMPTY_CHUNK_RSP = {cpr_pkg::KIND_FRAME, TX_CHUNK, 4'd0, 64'd0};
   localparam frame_rsp_type MODEM_RSP     = {cpr_pkg::KIND_MODEM, 29'd0, 4'd0, 64'd0};
   localparam frame_rsp_type CONFIRM_RSP   = {cpr_pkg::KIND_CONFIRM, 29'd0, 4'd0, 64'd0};

   typedef struct packed {
      logic        mode;
      logic [28:0] frame_id;
      logic [7:0]  data0;
      logic [7:0]  data1;
      logic [9:0]  load_address;
      logic [7:0]  load_byte;
   } rx_beat_type;

   typedef struct packed {
      rx_beat_type   beat;
      logic          typed;
      frame_rsp_type want;
   } script_row_type;

   logic        clock = 1'b0;
   logic        reset;
   logic        csr_valid;
   logic        csr_ready;
   logic [10:0] csr_payload_length;
   logic        req_valid;
   logic        req_ready;
   logic        req_mode;
   logic [28:0] req_frame_id;
   logic [7:0]  req_first_data_byte;
   logic [7:0]  req_second_data_byte;
   logic [9:0]  req_load_address;
   logic [7:0]  req_load_byte;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [1:0]  rsp_result_kind;
   logic [28:0] rsp_tx_id;
   logic [3:0]  rsp_tx_length;
   logic [7:0]  rsp_tx_byte0;
   logic [7:0]  rsp_tx_byte1;
   logic [7:0]  rsp_tx_byte2;
   logic [7:0]  rsp_tx_byte3;
   logic [7:0]  rsp_tx_byte4;
   logic [7:0]  rsp_tx_byte5;
   logic [7:0]  rsp_tx_byte6;
   logic [7:0]  rsp_tx_byte7;

   // Responder state as the bench sees it
   logic [10:0] model_length;
   logic [2:0]  model_exchanges;
   logic [7:0]  model_chunks;
   logic [10:0] model_sent;
   logic [1:0]  model_acks;
   logic [7:0]  model_store [STORE_DEPTH];
   bit          store_loaded [STORE_DEPTH];

   frame_rsp_type pending_rsp [$];
   frame_rsp_type seen_want;
   cpr_pkg::frame_data_type seen_data;

   int failures = 0;
   int rsp_checked = 0;
   int beats_sent = 0;
   int settings_written = 0;
   bit source_calm = 1'b0;
   bit sink_calm = 1'b0;

   always #5 clock = ~clock;

   can_chunked_payload_responder_core dut (
      .clock                (clock),
      .reset                (reset),
      .csr_valid            (csr_valid),
      .csr_ready            (csr_ready),
      .csr_payload_length   (csr_payload_length),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_mode             (req_mode),
      .req_frame_id         (req_frame_id),
      .req_first_data_byte  (req_first_data_byte),
      .req_second_data_byte (req_second_data_byte),
      .req_load_address     (req_load_address),
      .req_load_byte        (req_load_byte),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_result_kind      (rsp_result_kind),
      .rsp_tx_id            (rsp_tx_id),
      .rsp_tx_length        (rsp_tx_length),
      .rsp_tx_byte0         (rsp_tx_byte0),
      .rsp_tx_byte1         (rsp_tx_byte1),
      .rsp_tx_byte2         (rsp_tx_byte2),
      .rsp_tx_byte3         (rsp_tx_byte3),
      .rsp_tx_byte4         (rsp_tx_byte4),
      .rsp_tx_byte5         (rsp_tx_byte5),
      .rsp_tx_byte6         (rsp_tx_byte6),
      .rsp_tx_byte7         (rsp_tx_byte7)
   );

   function automatic int unsigned effective_length();
      return (model_length > STORE_DEPTH) ? STORE_DEPTH : model_length;
   endfunction

   // Size and start of the chunk that the next data request would read
   function automatic int unsigned chunk_span(output int unsigned first);
      int unsigned len_eff;
      len_eff = effective_length();
      first = model_sent;
      if (model_exchanges > EXCH_DEVICE && model_chunks != 8'd0 &&
          model_chunks <= len_eff / 8 + 1 && model_sent < len_eff)
         return (len_eff - model_sent > 8) ? 8 : len_eff - model_sent;
      return 0;
   endfunction

   // Advance the responder state by one beat and give the result it causes
   function automatic bit predict_response(input rx_beat_type b, output frame_rsp_type rsp);
      int unsigned last_chunk;
      int unsigned first;
      int unsigned count;
      int unsigned total;
      bit hit;
      rsp = NO_RSP;
      hit = 1'b0;
      last_chunk = effective_length() / 8 + 1;
      if (b.mode == BEAT_LOAD) begin
         model_store[b.load_address] = b.load_byte;
         store_loaded[b.load_address] = 1'b1;
      end else if (b.frame_id == RX_POLL) begin
         rsp = (model_exchanges == 3'd0) ? HANDSHAKE_RSP : POLL_ZERO_RSP;
         hit = 1'b1;
         if (model_exchanges < EXCH_MAX) model_exchanges++;
      end else if (b.frame_id == RX_DATA_REQ) begin
         if (model_exchanges == EXCH_DEVICE) begin
            rsp = DEVICE_RSP;
            hit = 1'b1;
         end else if (model_exchanges > EXCH_DEVICE && model_chunks == 8'd0) begin
            rsp = BEGIN_RSP;
            hit = 1'b1;
            model_chunks++;
         end else if (model_exchanges > EXCH_DEVICE && model_chunks <= last_chunk) begin
            count = chunk_span(first);
            rsp = {cpr_pkg::KIND_FRAME, TX_CHUNK, 4'(count), 64'd0};
            for (int i = 0; i < count; i++) rsp.tx_data[i] = model_store[first + i];
            hit = 1'b1;
            total = model_sent + count;
            model_sent = (total > 11'h7FF) ? 11'h7FF : total[10:0];
            if (model_chunks < CHUNK_MAX) model_chunks++;
         end else if (model_chunks == last_chunk + 1) begin
            rsp = END_RSP;
            hit = 1'b1;
            if (model_chunks < CHUNK_MAX) model_chunks++;
         end
         if (model_exchanges < EXCH_MAX) model_exchanges++;
      end else if (b.frame_id == RX_MODEM && b.data0 == 8'd0 && b.data1 == 8'd0) begin
         rsp = MODEM_RSP;
         hit = 1'b1;
      end else if (b.frame_id == RX_ACK) begin
         if (model_acks < ACK_MAX) model_acks++;
         if (model_acks == ACK_CONFIRM) begin
            rsp = CONFIRM_RSP;
            hit = 1'b1;
         end
      end
      return hit;
   endfunction

   // Mostly no gap, sometimes a few cycles, now and then a long one
   function automatic int pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 96) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   function automatic rx_beat_type random_fields();
      rx_beat_type b;
      b.mode = 1'($urandom_range(0, 1));
      b.frame_id = 29'($urandom);
      b.data0 = 8'($urandom);
      b.data1 = 8'($urandom);
      b.load_address = 10'($urandom);
      b.load_byte = 8'($urandom);
      return b;
   endfunction

   // Well-formed exchange traffic with random content, plus some ignored noise
   function automatic rx_beat_type random_beat();
      rx_beat_type b;
      int unsigned pick;
      logic [28:0] base;
      b = random_fields();
      b.mode = BEAT_FRAME;
      pick = $urandom_range(0, 99);
      if (pick < 40) b.frame_id = RX_DATA_REQ;
      else if (pick < 60) b.frame_id = RX_POLL;
      else if (pick < 66) begin
         b.frame_id = RX_MODEM;
         b.data0 = 8'd0;
         b.data1 = 8'd0;
      end else if (pick < 72) b.frame_id = RX_ACK;
      else if (pick < 84) b.mode = BEAT_LOAD;
      else begin
         if (pick < 88) b.frame_id = RX_MODEM;
         else if (pick < 94) begin
            case ($urandom_range(0, 3))
               0: base = RX_POLL;
               1: base = RX_DATA_REQ;
               2: base = RX_MODEM;
               default: base = RX_ACK;
            endcase
            b.frame_id = base ^ (29'd1 << $urandom_range(0, 28));
         end
      end
      return b;
   endfunction

   function automatic script_row_type row(input logic mode, input logic [28:0] id,
         input logic [7:0] d0, input logic [7:0] d1, input logic [9:0] addr,
         input logic [7:0] lbyte, input logic typed, input frame_rsp_type want);
      script_row_type r;
      r.beat = {mode, id, d0, d1, addr, lbyte};
      r.typed = typed;
      r.want = want;
      return r;
   endfunction

   // Present one beat and hold it until accepted
   task automatic push_beat(input rx_beat_type b);
      req_valid <= 1'b1;
      req_mode <= b.mode;
      req_frame_id <= b.frame_id;
      req_first_data_byte <= b.data0;
      req_second_data_byte <= b.data1;
      req_load_address <= b.load_address;
      req_load_byte <= b.load_byte;
      do @(posedge clock); while (req_ready !== 1'b1);
      beats_sent++;
   endtask

   task automatic pause_source();
      int gap;
      gap = source_calm ? 0 : pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Load any payload byte that the coming data request would read before it was written
   task automatic fill_store_for(input rx_beat_type b);
      int unsigned first;
      int unsigned count;
      rx_beat_type ld;
      frame_rsp_type unused;
      if (b.mode == BEAT_LOAD || b.frame_id != RX_DATA_REQ) return;
      count = chunk_span(first);
      for (int unsigned a = first; a < first + count; a++) begin
         if (!store_loaded[a]) begin
            ld = random_fields();
            ld.mode = BEAT_LOAD;
            ld.load_address = a[9:0];
            void'(predict_response(ld, unused));
            push_beat(ld);
            pause_source();
         end
      end
   endtask

   task automatic issue(input rx_beat_type b, input logic typed, input frame_rsp_type want);
      frame_rsp_type rsp;
      bit hit;
      fill_store_for(b);
      hit = predict_response(b, rsp);
      if (typed) pending_rsp.push_back(want);
      else if (hit) pending_rsp.push_back(rsp);
      push_beat(b);
   endtask

   // Stop sending and wait for every expected result, then let the pipeline settle
   task automatic drain_results();
      int waited;
      req_valid <= 1'b0;
      waited = 0;
      while (pending_rsp.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      if (pending_rsp.size() != 0) begin
         $error("%0d expected results never arrived", pending_rsp.size());
         failures++;
         pending_rsp.delete();
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_length(input logic [10:0] value);
      csr_valid <= 1'b1;
      csr_payload_length <= value;
      do @(posedge clock); while (csr_ready !== 1'b1);
      csr_valid <= 1'b0;
      model_length = value;
      settings_written++;
   endtask

   // Result side: stall at random, with calm stretches
   initial begin
      int hold_left;
      int g;
      hold_left = 0;
      rsp_ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            g = ($urandom_range(0, 2) == 0) ? pick_gap() : 0;
            if (g == 0 || sink_calm) rsp_ready <= 1'b1;
            else begin
               rsp_ready <= 1'b0;
               hold_left = g - 1;
            end
         end
      end
   end

   // Compare each result beat with the oldest expectation
   always @(posedge clock) begin
      if (reset === 1'b0 && rsp_valid === 1'b1 && rsp_ready === 1'b1) begin
         if (pending_rsp.size() == 0) begin
            $error("result beat with no expectation waiting: kind %0d, tx_id %h",
                   rsp_result_kind, rsp_tx_id);
            failures++;
         end else begin
            seen_want = pending_rsp.pop_front();
            seen_data = {rsp_tx_byte7, rsp_tx_byte6, rsp_tx_byte5, rsp_tx_byte4,
                         rsp_tx_byte3, rsp_tx_byte2, rsp_tx_byte1, rsp_tx_byte0};
            rsp_checked++;
            if (rsp_result_kind !== seen_want.kind) begin
               $error("result_kind: expected %0d, got %0d", seen_want.kind, rsp_result_kind);
               failures++;
            end
            if (rsp_tx_id !== seen_want.tx_id) begin
               $error("tx_id: expected %h, got %h", seen_want.tx_id, rsp_tx_id);
               failures++;
            end
            if (rsp_tx_length !== seen_want.tx_length) begin
               $error("tx_length: expected %0d, got %0d", seen_want.tx_length, rsp_tx_length);
               failures++;
            end
            for (int i = 0; i < 8; i++) begin
               if (seen_data[i] !== seen_want.tx_data[i]) begin
                  $error("tx_byte%0d: expected %h, got %h", i, seen_want.tx_data[i],
                         seen_data[i]);
                  failures++;
               end
            end
         end
      end
   end

   initial begin
      script_row_type script [$];
      int plan_length [7];
      int plan_items [7];
      rx_beat_type b;
      int phase_start;

      reset <= 1'b1;
      csr_valid <= 1'b0;
      csr_payload_length <= '0;
      req_valid <= 1'b0;
      req_mode <= BEAT_FRAME;
      req_frame_id <= '0;
      req_first_data_byte <= '0;
      req_second_data_byte <= '0;
      req_load_address <= '0;
      req_load_byte <= '0;
      model_length = '0;
      model_exchanges = '0;
      model_chunks = '0;
      model_sent = '0;
      model_acks = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Directed table: a length that is a multiple of eight, so the last chunk is empty
      write_length(11'd16);
      script.push_back(row(BEAT_FRAME, RX_POLL, 8'h00, 8'h00, 10'd0, 8'h00, TYPED,
                           HANDSHAKE_RSP));
      script.push_back(row(BEAT_FRAME, RX_POLL, 8'h00, 8'h00, 10'd0, 8'h00, TYPED,
                           POLL_ZERO_RSP));
      script.push_back(row(BEAT_LOAD, 29'd0, 8'h00, 8'h00, 10'd0, 8'hFF, PREDICTED, NO_RSP));
      script.push_back(row(BEAT_LOAD, RX_POLL, 8'hFF, 8'hFF, 10'd1023, 8'h00, PREDICTED,
                           NO_RSP));
      // Third exchange: a data request too early counts but gives nothing
      script.push_back(row(BEAT_FRAME, RX_DATA_REQ, 8'h00, 8'h00, 10'd0, 8'h00, PREDICTED,
                           NO_RSP));
      script.push_back(row(BEAT_FRAME, RX_DATA_REQ, 8'h00, 8'h00, 10'd0, 8'h00, TYPED,
                           DEVICE_RSP));
      script.push_back(row(BEAT_FRAME, RX_DATA_REQ, 8'h00, 8'h00, 10'd0, 8'h00, TYPED,
                           BEGIN_RSP));
      script.push_back(row(BEAT_FRAME, RX_DATA_REQ, 8'hFF, 8'hFF, 10'd1023, 8'hFF,
                           PREDICTED, NO_RSP));
      script.push_back(row(BEAT_FRAME, RX_DATA_REQ, 8'h00, 8'h00, 10'd0, 8'h00, PREDICTED,
                           NO_RSP));
      script.push_back(row(BEAT_FRAME, RX_DATA_REQ, 8'h00, 8'h00, 10'd0, 8'h00, TYPED,
                           EMPTY_CHUNK_RSP));
      script.push_back(row(BEAT_FRAME, RX_DATA_REQ, 8'h00, 8'h00, 10'd0, 8'h00, TYPED,
                           END_RSP));
      script.push_back(row(BEAT_FRAME, RX_DATA_REQ, 8'h00, 8'h00, 10'd0, 8'h00, PREDICTED,
                           NO_RSP));
      script.push_back(row(BEAT_FRAME, RX_MODEM, 8'h00, 8'h00, 10'd0, 8'h00, TYPED,
                           MODEM_RSP));
      script.push_back(row(BEAT_FRAME, RX_MODEM, 8'hFF, 8'h00, 10'd0, 8'h00, PREDICTED,
                           NO_RSP));
      script.push_back(row(BEAT_FRAME, RX_MODEM, 8'h00, 8'hFF, 10'd0, 8'h00, PREDICTED,
                           NO_RSP));
      // Only the second acknowledge confirms; the count then saturates
      script.push_back(row(BEAT_FRAME, RX_ACK, 8'h00, 8'h00, 10'd0, 8'h00, PREDICTED,
                           NO_RSP));
      script.push_back(row(BEAT_FRAME, RX_ACK, 8'h00, 8'h00, 10'd0, 8'h00, TYPED,
                           CONFIRM_RSP));
      script.push_back(row(BEAT_FRAME, RX_ACK, 8'hFF, 8'hFF, 10'd0, 8'h00, PREDICTED,
                           NO_RSP));
      script.push_back(row(BEAT_FRAME, RX_ACK, 8'h00, 8'h00, 10'd0, 8'h00, PREDICTED,
                           NO_RSP));
      script.push_back(row(BEAT_FRAME, 29'h1FFF_FFFF, 8'hFF, 8'hFF, 10'd1023, 8'hFF,
                           PREDICTED, NO_RSP));
      script.push_back(row(BEAT_FRAME, 29'd0, 8'h00, 8'h00, 10'd0, 8'h00, PREDICTED,
                           NO_RSP));
      script.push_back(row(BEAT_FRAME, RX_POLL, 8'hFF, 8'hFF, 10'd1023, 8'hFF, TYPED,
                           POLL_ZERO_RSP));
      foreach (script[i]) begin
         issue(script[i].beat, script[i].typed, script[i].want);
         pause_source();
      end
      drain_results();

      // Random phases over several payload lengths, extremes included
      plan_length = '{8, 40 + $urandom_range(0, 15), 0, $urandom_range(64, 300), 2047,
                      $urandom_range(0, 2047), 1024};
      plan_items = '{80, 100, 80, 120, 140, 100, 180};
      for (int p = 0; p < 7; p++) begin
         source_calm = ($urandom_range(0, 4) == 0);
         sink_calm = ($urandom_range(0, 4) == 0);
         write_length(plan_length[p][10:0]);
         phase_start = beats_sent;
         while (beats_sent - phase_start < plan_items[p]) begin
            b = random_beat();
            issue(b, PREDICTED, NO_RSP);
            if ($urandom_range(0, 59) == 0) drain_results();
            else pause_source();
         end
         drain_results();
      end

      $display("Checked %0d result beats from %0d request beats over %0d length settings.",
               rsp_checked, beats_sent, settings_written);
      $display("Payload stream reached byte %0d with the chunk counter at %0d.",
               model_sent, model_chunks);
      if (failures == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

   // Bound the run well beyond the slowest legal pace
   initial begin
      #10_000_000;
      $error("run exceeded its time limit");
      $display("Regression FAIL");
      $finish;
   end

endmodule
